[rtl/core/pec_pkg.sv]
// Shared constants, tables and stage types of the palette emphasis pixel converter.
package pec_pkg;

  localparam int PAL_ENTRIES = 64;  // palette RAM depth, a power of two
  localparam int PAL_AW      = $clog2(PAL_ENTRIES);
  localparam int FRAC_BITS   = 12;  // fraction bits of the emphasis factors
  localparam int FAC_W       = FRAC_BITS + 1;  // every factor lies below 2.0
  localparam int CH_W        = 8;
  localparam int RGB_W       = 3 * CH_W;
  localparam int PROD_W      = CH_W + FAC_W;
  localparam int IDX_W       = 6;
  localparam int EMPH_W      = 3;
  localparam int PIX_W       = 24;
  localparam int FMT_W       = 2;
  localparam int CFG_AW      = 3;
  localparam int CFG_DW      = 32;

  localparam logic [FMT_W-1:0] FMT_555   = 2'd0;
  localparam logic [FMT_W-1:0] FMT_565   = 2'd1;
  localparam logic [FMT_W-1:0] FMT_888   = 2'd2;
  localparam logic [FMT_W-1:0] FMT_RESET = FMT_888;

  localparam logic SRC_TABLE = 1'b0;
  localparam logic SRC_RAM   = 1'b1;

  localparam logic FUNC_WRITE   = 1'b0;
  localparam logic FUNC_CONVERT = 1'b1;

  // register select, taken from address bit 2
  localparam logic REG_FORMAT = 1'b0;
  localparam logic REG_SOURCE = 1'b1;

  // Round milli/1000 to the nearest step of the factor grid.
  function automatic logic [FAC_W-1:0] milli_to_fac(input int unsigned milli);
    int unsigned scaled;
    scaled = ((milli << FRAC_BITS) + 500) / 1000;
    return FAC_W'(scaled);
  endfunction

  // Emphasis factors per code: red, green, blue.
  localparam logic [FAC_W-1:0] FACTOR_TAB [8][3] = '{
    '{milli_to_fac(1000), milli_to_fac(1000), milli_to_fac(1000)},
    '{milli_to_fac(1239), milli_to_fac(915),  milli_to_fac(743)},
    '{milli_to_fac(794),  milli_to_fac(1086), milli_to_fac(882)},
    '{milli_to_fac(1019), milli_to_fac(980),  milli_to_fac(653)},
    '{milli_to_fac(905),  milli_to_fac(1026), milli_to_fac(1277)},
    '{milli_to_fac(1023), milli_to_fac(908),  milli_to_fac(979)},
    '{milli_to_fac(741),  milli_to_fac(987),  milli_to_fac(1001)},
    '{milli_to_fac(750),  milli_to_fac(750),  milli_to_fac(750)}
  };

  // Fixed PAL palette, packed r:g:b.
  localparam logic [RGB_W-1:0] PAL_TABLE [64] = '{
    24'h5B5B5B, 24'h0000B4, 24'h0000A0, 24'h3D00B1,
    24'h690074, 24'h5B0000, 24'h5F0000, 24'h411800,
    24'h102F00, 24'h084A08, 24'h006700, 24'h004212,
    24'h00286D, 24'h000000, 24'h000000, 24'h000000,
    24'hE7D5C4, 24'h0040FF, 24'h220EDC, 24'h6B47FF,
    24'h9F00D7, 24'hD70A68, 24'hC80000, 24'hB15400,
    24'h5B6A00, 24'h038C00, 24'h009900, 24'h00A22C,
    24'h0072A4, 24'h000000, 24'h000000, 24'h000000,
    24'hF8F8F8, 24'h64B4FF, 24'h8EABFF, 24'hC55BFF,
    24'hF248FF, 24'hFF49DF, 24'hFF6D48, 24'hE2A749,
    24'hFFE000, 24'h75E300, 24'h8AE571, 24'h2EB878,
    24'h13E2E5, 24'h787878, 24'h000000, 24'h000000,
    24'hFFFFFF, 24'hBEF2FF, 24'hB8B8F8, 24'hD8B8F8,
    24'hFFB6FF, 24'hFFC3FF, 24'hFFD1C7, 24'hFFE6C8,
    24'hF8ED88, 24'hDDFF83, 24'hB8F8B8, 24'hD7F8F5,
    24'hC5FFFF, 24'hF8D8F8, 24'h000000, 24'h000000
  };

  typedef struct packed {
    logic [EMPH_W-1:0] emph;
    logic [RGB_W-1:0]  base;
  } lk_t;

  typedef struct packed {
    logic [PROD_W-1:0] r;
    logic [PROD_W-1:0] g;
    logic [PROD_W-1:0] b;
  } prod_t;

endpackage

[rtl/core/pec_cfg.sv]
// Configuration registers behind the APB-style port.
module pec_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [pec_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [pec_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [pec_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                         cfg_pready,
  output logic [pec_pkg::FMT_W-1:0]    fmt,
  output logic                         src
);
  import pec_pkg::*;

  logic [FMT_W-1:0] fmt_r, fmt_nxt;
  logic             src_r, src_nxt;
  logic             wr_en;
  logic             reg_sel;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_sel    = cfg_paddr[2];

  always_comb begin
    fmt_nxt = fmt_r;
    src_nxt = src_r;
    if (wr_en) begin
      case (reg_sel)
        REG_FORMAT: fmt_nxt = cfg_pwdata[FMT_W-1:0];
        REG_SOURCE: src_nxt = cfg_pwdata[0];
        default:    fmt_nxt = fmt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= FMT_RESET;
      src_r <= SRC_TABLE;
    end else begin
      fmt_r <= fmt_nxt;
      src_r <= src_nxt;
    end
  end

  always_comb begin
    case (reg_sel)
      REG_FORMAT: cfg_prdata = CFG_DW'(fmt_r);
      REG_SOURCE: cfg_prdata = CFG_DW'(src_r);
      default:    cfg_prdata = '0;
    endcase
  end

  assign fmt = fmt_r;
  assign src = src_r;

endmodule

[rtl/core/pec_lookup.sv]
// Stage 1: palette RAM write and read, fixed table lookup, base color select.
module pec_lookup (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_func,
  input  logic [pec_pkg::IDX_W-1:0]   in_idx,
  input  logic [pec_pkg::EMPH_W-1:0]  in_emph,
  input  logic [pec_pkg::RGB_W-1:0]   in_rgb,
  input  logic                        src,
  output logic                        lk_valid,
  output pec_pkg::lk_t                lk,
  input  logic                        dn_ready
);
  import pec_pkg::*;

  logic [RGB_W-1:0]  mem [PAL_ENTRIES];
  logic [PAL_AW-1:0] addr;
  logic              fire;

  logic              v_r, v_nxt;
  logic [RGB_W-1:0]  ram_q_r;
  logic [RGB_W-1:0]  tab_r, tab_nxt;
  logic              src_r;
  logic [EMPH_W-1:0] emph_r;

  // depth is a power of two, so the modulo is a mask
  assign addr     = PAL_AW'(in_idx % PAL_ENTRIES);
  assign in_ready = !v_r || dn_ready;
  assign fire     = in_valid && in_ready;
  assign tab_nxt  = PAL_TABLE[in_idx];

  // only conversions travel on; palette writes end here
  assign v_nxt = in_ready ? (fire && (in_func == FUNC_CONVERT)) : v_r;

  always_ff @(posedge clk) begin
    if (fire && (in_func == FUNC_WRITE)) begin
      mem[addr] <= in_rgb;
    end
    if (in_ready) begin
      ram_q_r <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      tab_r  <= tab_nxt;
      src_r  <= src;
      emph_r <= in_emph;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign lk_valid = v_r;
  assign lk.emph  = emph_r;
  assign lk.base  = (src_r == SRC_RAM) ? ram_q_r : tab_r;

endmodule

[rtl/core/pec_scale.sv]
// Stage 2: multiply each channel by its emphasis factor.
module pec_scale (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           up_valid,
  output logic           up_ready,
  input  pec_pkg::lk_t   lk,
  output logic           pr_valid,
  output pec_pkg::prod_t pr,
  input  logic           dn_ready
);
  import pec_pkg::*;

  logic  v_r, v_nxt;
  prod_t pr_r, pr_nxt;

  assign up_ready = !v_r || dn_ready;
  assign v_nxt    = up_ready ? up_valid : v_r;

  always_comb begin
    pr_nxt.r = PROD_W'(lk.base[3*CH_W-1:2*CH_W]) * PROD_W'(FACTOR_TAB[lk.emph][0]);
    pr_nxt.g = PROD_W'(lk.base[2*CH_W-1:CH_W])   * PROD_W'(FACTOR_TAB[lk.emph][1]);
    pr_nxt.b = PROD_W'(lk.base[CH_W-1:0])        * PROD_W'(FACTOR_TAB[lk.emph][2]);
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      pr_r <= pr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign pr_valid = v_r;
  assign pr       = pr_r;

endmodule

[rtl/core/pec_pack.sv]
// Stage 3: truncate, saturate and pack the pixel into the output register.
module pec_pack (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       up_valid,
  output logic                       up_ready,
  input  pec_pkg::prod_t             pr,
  input  logic [pec_pkg::FMT_W-1:0]  fmt,
  output logic                       out_valid,
  output logic [pec_pkg::PIX_W-1:0]  out_pixel,
  input  logic                       out_ready
);
  import pec_pkg::*;

  localparam int SCL_W = PROD_W - FRAC_BITS;

  logic              v_r, v_nxt;
  logic [PIX_W-1:0]  pix_r, pix_nxt;
  logic [CH_W-1:0]   r8, g8, b8;

  function automatic logic [CH_W-1:0] sat_ch(input logic [PROD_W-1:0] p);
    logic [SCL_W-1:0] s;
    s = p[PROD_W-1:FRAC_BITS];
    return (s > SCL_W'(8'hFF)) ? 8'hFF : s[CH_W-1:0];
  endfunction

  assign up_ready = !v_r || out_ready;
  assign v_nxt    = up_ready ? up_valid : v_r;

  assign r8 = sat_ch(pr.r);
  assign g8 = sat_ch(pr.g);
  assign b8 = sat_ch(pr.b);

  always_comb begin
    case (fmt)
      FMT_555: pix_nxt = PIX_W'({r8[7:3], g8[7:3], b8[7:3]});
      FMT_565: pix_nxt = PIX_W'({r8[7:3], g8[7:2], b8[7:3]});
      default: pix_nxt = {r8, g8, b8};  // 888 and the reserved code
    endcase
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      pix_r <= pix_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_pixel = pix_r;

endmodule

[rtl/core/palette_emphasis_pixel_converter.sv]
// Top level of the palette emphasis pixel converter.
//
//   channel  direction  handshake             contents
//   in_      slave      in_tvalid/in_tready   palette write or pixel conversion item
//   out_     master     out_tvalid/out_tready packed pixel item
//   cfg_     APB slave  psel/penable, pready  pixel_format @0x0, palette_source @0x4
//
// One item is taken per cycle while in_tready is high. A conversion item passes
// three register stages (RAM/table read, channel multiply, saturate and pack);
// out_tvalid rises once the item is held in the pack register.
// A palette write is done at its accept edge and gives no output item; a
// conversion accepted the next cycle already reads the new entry.
// rst_n (synchronous) clears the valid bits and the configuration registers; the
// palette RAM keeps its contents and is undefined until written.
// Each stage holds while its successor is full and stalled, so bubbles close up
// and nothing is lost or repeated under backpressure.
module palette_emphasis_pixel_converter (
  input  logic                         clk,
  input  logic                         rst_n,
  // input item
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // [5:0] color_index, [8:6] emphasis, [16:9] red_in, [24:17] green_in,
  // [32:25] blue_in, [39:33] zero
  input  logic [39:0]                  in_tdata,
  // [0] func
  input  logic                         in_tuser,
  // result item
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // [23:0] pixel_value
  output logic [pec_pkg::PIX_W-1:0]    out_tdata,
  // configuration
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [pec_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [pec_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [pec_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                         cfg_pready
);
  import pec_pkg::*;

  logic [FMT_W-1:0]  fmt;
  logic              src;

  logic [IDX_W-1:0]  in_idx;
  logic [EMPH_W-1:0] in_emph;
  logic [RGB_W-1:0]  in_rgb;

  logic              lk_valid, lk_ready;
  lk_t               lk;
  logic              pr_valid, pr_ready;
  prod_t             pr;

  // unpack the input item; the palette word is stored as r:g:b
  assign in_idx  = in_tdata[5:0];
  assign in_emph = in_tdata[8:6];
  assign in_rgb  = {in_tdata[16:9], in_tdata[24:17], in_tdata[32:25]};

  pec_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .fmt         (fmt),
    .src         (src)
  );

  // stage 1: write or read the palette and pick the base color
  pec_lookup u_lookup (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_func  (in_tuser),
    .in_idx   (in_idx),
    .in_emph  (in_emph),
    .in_rgb   (in_rgb),
    .src      (src),
    .lk_valid (lk_valid),
    .lk       (lk),
    .dn_ready (lk_ready)
  );

  // stage 2: apply the emphasis factors
  pec_scale u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (lk_valid),
    .up_ready (lk_ready),
    .lk       (lk),
    .pr_valid (pr_valid),
    .pr       (pr),
    .dn_ready (pr_ready)
  );

  // stage 3: saturate, pack and hold the result for the consumer
  pec_pack u_pack (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (pr_valid),
    .up_ready  (pr_ready),
    .pr        (pr),
    .fmt       (fmt),
    .out_valid (out_tvalid),
    .out_pixel (out_tdata),
    .out_ready (out_tready)
  );

endmodule
